### hdl/checked_number_field_parser_macros.svh
// Assertion macros for the checker file of the number field parser.
// No dependencies; take in with `include where assertions are written.
`ifndef CHECKED_NUMBER_FIELD_PARSER_MACROS_SVH
`define CHECKED_NUMBER_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CNFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CNFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cnfp_pkg.sv
// Types and constants of the checked number field parser.
// No dependencies; compile before every other file of the block.
package cnfp_pkg;

    localparam int VAL_W  = 64;
    localparam int CNT_W  = 9;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX        = CNT_W'(511);
    localparam logic [CNT_W-1:0] FIXED_BYTES      = CNT_W'(8);
    localparam logic [CNT_W-1:0] VARINT_MAX_BYTES = CNT_W'(9);
    localparam logic [CNT_W-1:0] VARINT_LAST_IDX  = CNT_W'(8);

    typedef enum logic [1:0] {
        FMT_AMOUNT      = 2'd0,
        FMT_PLAIN       = 2'd1,
        FMT_VARUINT     = 2'd2,
        FMT_UNSUPPORTED = 2'd3
    } fmt_code_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_LENGTH = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_BAD    = 2'd3
    } check_mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_FORMAT = 2'd0,
        REG_MODE   = 2'd1,
        REG_LOW    = 2'd2,
        REG_HIGH   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        fmt_code_t         fmt;
        check_mode_t       mode;
        logic [VAL_W-1:0]  bound_low;
        logic [VAL_W-1:0]  bound_high;
    } cfg_t;

    typedef struct packed {
        logic [VAL_W-1:0] decoded_value;
        logic             invalid;
    } result_t;

endpackage

### hdl/cnfp_ifs.sv
// Channel interfaces of the checked number field parser: field bytes,
// results and configuration writes. Depends on cnfp_pkg.
interface cnfp_field_if import cnfp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] value_byte;
    logic              last_byte;

    modport source (output valid, value_byte, last_byte, input ready);
    modport sink   (input valid, value_byte, last_byte, output ready);
endinterface

interface cnfp_result_if import cnfp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] decoded_value;
    logic             invalid;

    modport source (output valid, decoded_value, invalid, input ready);
    modport sink   (input valid, decoded_value, invalid, output ready);
endinterface

interface cnfp_cfg_if import cnfp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/checked_number_field_parser.sv
// Top level of the checked number field parser: input stage, config
// registers and result register. Depends on cnfp_pkg, cnfp_ifs, cnfp_core.
//
//   channel   dir   beat payload                     notes
//   cfg       in    index (2b), data (64b)           always ready
//   field     in    value_byte (8b), last_byte (1b)  one byte per beat
//   result    out   decoded_value (64b), invalid     one beat per field
//
// One byte a cycle sustained unless a last byte waits; a byte passes the
// input register, then the decode logic, and a last byte moves on into
// the result register. Throughput is set by the single result register:
// a last byte waits only while a result is held by the sink.
// Reset clears field state, config (all zero) and both valid flags.
module checked_number_field_parser import cnfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cnfp_cfg_if.sink    cfg,
    cnfp_field_if.sink  field,
    cnfp_result_if.source result
);

    cfg_t              cfg_reg;
    logic              s0_valid_reg;
    logic [BYTE_W-1:0] s0_byte_reg;
    logic              s0_last_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic    out_free;
    logic    s0_adv;
    result_t core_res;

    assign cfg.ready   = 1'b1;
    assign out_free    = !out_valid_reg || result.ready;
    assign s0_adv      = s0_valid_reg && (!s0_last_reg || out_free);
    assign field.ready = !s0_valid_reg || s0_adv;

    assign result.valid         = out_valid_reg;
    assign result.decoded_value = out_reg.decoded_value;
    assign result.invalid       = out_reg.invalid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_FORMAT: cfg_reg.fmt        <= fmt_code_t'(cfg.data[1:0]);
                REG_MODE:   cfg_reg.mode       <= check_mode_t'(cfg.data[1:0]);
                REG_LOW:    cfg_reg.bound_low  <= cfg.data;
                REG_HIGH:   cfg_reg.bound_high <= cfg.data;
                default:    cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (field.valid && field.ready)
                s0_valid_reg <= 1'b1;
            else if (s0_adv)
                s0_valid_reg <= 1'b0;

            if (s0_adv && s0_last_reg)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload: hold unless a new beat is loaded
    always_ff @(posedge clk)
    begin
        if (field.valid && field.ready)
        begin
            s0_byte_reg <= field.value_byte;
            s0_last_reg <= field.last_byte;
        end
        if (s0_adv && s0_last_reg)
            out_reg <= core_res;
    end

    cnfp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s0_adv),
        .value_byte (s0_byte_reg),
        .last_byte  (s0_last_reg),
        .cfg        (cfg_reg),
        .res        (core_res)
    );

endmodule

### hdl/cnfp_core.sv
// Field state and per-byte decode of the number field parser: accumulate,
// track varint termination and errors, run the final checks.
// Depends on cnfp_pkg.
module cnfp_core import cnfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] value_byte,
    input  logic              last_byte,
    input  cfg_t              cfg,
    output result_t           res
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic             term_reg, term_next;
    logic             err_reg, err_next;

    logic [VAL_W-1:0] contrib;
    logic [6:0]       var_shift_full;
    logic [5:0]       var_shift;
    logic [VAL_W-1:0] count_wide;
    logic             bad;

    // 7 * index; only used while the index is below nine
    assign var_shift_full = ({3'b000, count_reg[3:0]} << 3) - {3'b000, count_reg[3:0]};
    assign var_shift      = var_shift_full[5:0];

    always_comb
    begin
        contrib   = '0;
        term_next = term_reg;
        err_next  = err_reg;
        case (cfg.fmt)
            FMT_AMOUNT, FMT_PLAIN:
            begin
                if (count_reg < FIXED_BYTES)
                    contrib = VAL_W'(value_byte) << {count_reg[2:0], 3'b000};
            end
            FMT_VARUINT:
            begin
                if (term_reg || count_reg >= VARINT_MAX_BYTES)
                    err_next = 1'b1;
                else
                begin
                    contrib = VAL_W'(value_byte[6:0]) << var_shift;
                    if (!value_byte[7])
                        term_next = 1'b1;
                    else if (count_reg == VARINT_LAST_IDX)
                        err_next = 1'b1;
                end
            end
            default: err_next = 1'b1;
        endcase

        acc_next   = acc_reg | contrib;
        count_next = (count_reg < COUNT_MAX) ? count_reg + CNT_W'(1) : count_reg;
        count_wide = VAL_W'(count_next);
    end

    // final checks, meaningful on the last byte only
    always_comb
    begin
        bad = err_next;
        case (cfg.fmt)
            FMT_AMOUNT, FMT_PLAIN:
                if (count_next != FIXED_BYTES)
                    bad = 1'b1;
            FMT_VARUINT:
                if (!term_next || acc_next[VAL_W-1:32] != '0)
                    bad = 1'b1;
            default: bad = 1'b1;
        endcase
        case (cfg.mode)
            MODE_NONE:
                if (cfg.bound_low != '0 || cfg.bound_high != '0)
                    bad = 1'b1;
            MODE_LENGTH:
                if (cfg.bound_low > count_wide || cfg.bound_high < count_wide)
                    bad = 1'b1;
            MODE_NUMBER:
                if (acc_next < cfg.bound_low || acc_next > cfg.bound_high)
                    bad = 1'b1;
            default: bad = 1'b1;
        endcase
        res.invalid       = bad;
        res.decoded_value = bad ? '0 : acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            acc_reg   <= '0;
            term_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                // clear for the next field
                count_reg <= '0;
                acc_reg   <= '0;
                term_reg  <= 1'b0;
                err_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                acc_reg   <= acc_next;
                term_reg  <= term_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

### hdl/cnfp_checker.sv
// Port-level assertions for the checked number field parser, bound to the
// top level. Depends on cnfp_pkg and checked_number_field_parser_macros.svh.
`include "checked_number_field_parser_macros.svh"

module cnfp_checker import cnfp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             field_ready,
    input logic             result_valid,
    input logic             result_ready,
    input logic [VAL_W-1:0] result_value,
    input logic             result_invalid
);

    // an invalid field never leaks a partial number
    `CNFP_ASSERT_SAME(a_invalid_zero, clk, rst_n, result_valid && result_invalid, result_value == '0, "invalid result carries a non-zero value")

    // with no result held, the input side must not stall
    `CNFP_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !result_valid, field_ready, "field stalled while result register empty")

    `CNFP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_value) && $stable(result_invalid), "stalled result beat changed")

endmodule

bind checked_number_field_parser cnfp_checker u_cnfp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .field_ready    (field.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_value   (result.decoded_value),
    .result_invalid (result.invalid)
);
